@@ sv/background_subtract_mask_unit_macros.svh @@
// assertion macros used by the checker file
`ifndef BACKGROUND_SUBTRACT_MASK_UNIT_MACROS_SVH
`define BACKGROUND_SUBTRACT_MASK_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define BSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/bsm_pkg.sv @@
package bsm_pkg;

    // frame geometry
    localparam int FRAME_PIXELS = 307200;
    localparam int POS_W        = $clog2(FRAME_PIXELS);

    // pixel and arithmetic widths
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int DIST_W   = CH_W + 2;
    localparam int THRESH_W = 10;
    localparam int TOTAL_W  = 27;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(20);

    // stream widths
    localparam int IN_DATA_W  = PIX_W;
    localparam int OUT_USED_W = PIX_W + 3 * TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [TOTAL_W-1:0] total_t;

    localparam total_t TOTAL_MAX = '1;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } pixel_t;

    // pixel entering the mask stage
    typedef struct packed {
        pixel_t pixel;
        logic   capture;
        logic   last;
    } in_item_t;

    // masked pixel handed to the accumulate stage
    typedef struct packed {
        pixel_t pixel;
        logic   fg;
        logic   last;
    } mask_item_t;

    // background memory access
    typedef struct packed {
        logic   wr_en;
        pos_t   wr_addr;
        pixel_t wr_data;
        logic   rd_en;
        pos_t   rd_addr;
    } ram_req_t;

    function automatic logic [CH_W-1:0] abs_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // accumulator add that sticks at the top value
    function automatic total_t sat_add(total_t acc, logic [CH_W-1:0] v);
        logic [TOTAL_W:0] s;
        s = {1'b0, acc} + (TOTAL_W + 1)'(v);
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

endpackage

@@ sv/bsm_bg_ram.sv @@
module bsm_bg_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/bsm_mask_stage.sv @@
module bsm_mask_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bsm_pkg::THRESH_W-1:0]  diff_threshold,
    // pixel in
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bsm_pkg::in_item_t             in_item,
    // background memory
    output bsm_pkg::ram_req_t             ram_req,
    input  bsm_pkg::pixel_t               ram_rd_data,
    // masked pixel out
    output logic                          out_valid,
    input  logic                          out_ready,
    output bsm_pkg::mask_item_t           out_item
);

    logic                  clearing_reg, clearing_next;
    bsm_pkg::pos_t         clr_addr_reg, clr_addr_next;
    bsm_pkg::pos_t         pos_reg, pos_next;
    logic                  s1_valid_reg, s1_valid_next;
    bsm_pkg::in_item_t     s1_item_reg;
    bsm_pkg::pos_t         s1_addr_reg;
    logic                  fwd_reg;
    bsm_pkg::pixel_t       fwd_data_reg;
    logic                  s2_valid_reg, s2_valid_next;
    bsm_pkg::mask_item_t   s2_item_reg;

    logic                        s2_free;
    logic                        s1_adv;
    logic                        accept;
    bsm_pkg::pixel_t             bg_pixel;
    logic [bsm_pkg::DIST_W-1:0]  sad_sum;
    logic                        fg;

    // stage handshakes
    assign s2_free  = !s2_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !clearing_reg && (!s1_valid_reg || s2_free);
    assign accept   = in_valid && in_ready;

    // memory access: clearing pass, else capture write-back and read of next position
    always_comb
    begin
        ram_req.rd_en   = accept;
        ram_req.rd_addr = pos_reg;
        if (clearing_reg)
        begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = clr_addr_reg;
            ram_req.wr_data = '0;
        end
        else
        begin
            ram_req.wr_en   = s1_adv && s1_item_reg.capture;
            ram_req.wr_addr = s1_addr_reg;
            ram_req.wr_data = s1_item_reg.pixel;
        end
    end

    // clearing pass and pixel position
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == bsm_pkg::pos_t'(bsm_pkg::FRAME_PIXELS - 1))
            begin
                clearing_next = 1'b0;
                clr_addr_next = '0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end

        pos_next = pos_reg;
        if (accept)
        begin
            if (in_item.last || pos_reg == bsm_pkg::pos_t'(bsm_pkg::FRAME_PIXELS - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // background select: captured pixel, forwarded write, or memory
    always_comb
    begin
        if (s1_item_reg.capture)
        begin
            bg_pixel = s1_item_reg.pixel;
        end
        else if (fwd_reg)
        begin
            bg_pixel = fwd_data_reg;
        end
        else
        begin
            bg_pixel = ram_rd_data;
        end
    end

    // summed absolute difference and threshold compare
    assign sad_sum = bsm_pkg::DIST_W'(bsm_pkg::abs_diff(s1_item_reg.pixel.red, bg_pixel.red))
                   + bsm_pkg::DIST_W'(bsm_pkg::abs_diff(s1_item_reg.pixel.green, bg_pixel.green))
                   + bsm_pkg::DIST_W'(bsm_pkg::abs_diff(s1_item_reg.pixel.blue, bg_pixel.blue));
    assign fg      = (sad_sum >= diff_threshold);

    // stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage payloads; forward a write that lands on the address read in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= in_item;
            s1_addr_reg  <= pos_reg;
            fwd_reg      <= ram_req.wr_en && (ram_req.wr_addr == pos_reg);
            fwd_data_reg <= ram_req.wr_data;
        end
        if (s1_adv)
        begin
            s2_item_reg.pixel <= fg ? s1_item_reg.pixel : '0;
            s2_item_reg.fg    <= fg;
            s2_item_reg.last  <= s1_item_reg.last;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

@@ sv/bsm_accum_out.sv @@
module bsm_accum_out (
    input  logic                            clk,
    input  logic                            rst_n,
    // masked pixel in
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bsm_pkg::mask_item_t             in_item,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsm_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    logic              out_valid_reg, out_valid_next;
    bsm_pkg::pixel_t   out_pixel_reg;
    logic              out_fg_reg;
    logic              out_last_reg;
    bsm_pkg::total_t   red_total_reg, green_total_reg, blue_total_reg;
    bsm_pkg::total_t   red_acc_reg, green_acc_reg, blue_acc_reg;
    bsm_pkg::total_t   red_sum, green_sum, blue_sum;
    logic              load;

    assign in_ready = !out_valid_reg || m_tready;
    assign load     = in_valid && in_ready;

    // masked channels are zero for background pixels, so the add leaves the sum alone
    assign red_sum   = bsm_pkg::sat_add(red_acc_reg, in_item.pixel.red);
    assign green_sum = bsm_pkg::sat_add(green_acc_reg, in_item.pixel.green);
    assign blue_sum  = bsm_pkg::sat_add(blue_acc_reg, in_item.pixel.blue);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // frame accumulators, restarted after the last pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            red_acc_reg   <= '0;
            green_acc_reg <= '0;
            blue_acc_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                red_acc_reg   <= in_item.last ? '0 : red_sum;
                green_acc_reg <= in_item.last ? '0 : green_sum;
                blue_acc_reg  <= in_item.last ? '0 : blue_sum;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_pixel_reg   <= in_item.pixel;
            out_fg_reg      <= in_item.fg;
            out_last_reg    <= in_item.last;
            red_total_reg   <= in_item.last ? red_sum : '0;
            green_total_reg <= in_item.last ? green_sum : '0;
            blue_total_reg  <= in_item.last ? blue_sum : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_fg_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{bsm_pkg::OUT_PAD_W{1'b0}}, blue_total_reg, green_total_reg,
                       red_total_reg, out_pixel_reg};

endmodule

@@ sv/background_subtract_mask_unit.sv @@
// Foreground mask against a stored background frame. Pixels come in raster order on the
// s_ stream, one transfer per clock sustained while m_tready stays high; each result
// leaves on the m_ stream after the background memory read, the difference and
// compare register and the output register. A pixel whose summed |dR|+|dG|+|dB| reaches
// the threshold passes through with tuser high, else it comes out as zero; with tuser
// high on the input the pixel is first written as the new background. The frame's
// channel sums come out with tlast. After reset the background memory is cleared one
// entry per cycle with s_tready low; the threshold port is always ready.
module background_subtract_mask_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel stream in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsm_pkg::IN_DATA_W-1:0]   s_tdata,   // red, green, blue
    input  logic                            s_tuser,   // capture_frame
    input  logic                            s_tlast,   // frame_last
    // result stream out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_out, green_out, blue_out, red_total, green_total, blue_total, zero pad
    output logic [bsm_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,   // is_foreground
    output logic                            m_tlast,   // frame_done
    // threshold write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsm_pkg::THRESH_W-1:0]    cfg_data
);

    logic [bsm_pkg::THRESH_W-1:0]  threshold_reg;
    bsm_pkg::in_item_t             in_item;
    bsm_pkg::ram_req_t             ram_req;
    bsm_pkg::pixel_t               ram_rd_data;
    logic                          mask_valid;
    logic                          mask_ready;
    bsm_pkg::mask_item_t           mask_item;

    // threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= bsm_pkg::THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // unpack the input transfer
    assign in_item.pixel   = bsm_pkg::pixel_t'(s_tdata);
    assign in_item.capture = s_tuser;
    assign in_item.last    = s_tlast;

    bsm_bg_ram #(
        .DEPTH (bsm_pkg::FRAME_PIXELS),
        .WIDTH (bsm_pkg::PIX_W)
    ) u_bg_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    bsm_mask_stage u_mask (
        .clk            (clk),
        .rst_n          (rst_n),
        .diff_threshold (threshold_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_item        (in_item),
        .ram_req        (ram_req),
        .ram_rd_data    (ram_rd_data),
        .out_valid      (mask_valid),
        .out_ready      (mask_ready),
        .out_item       (mask_item)
    );

    bsm_accum_out u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mask_valid),
        .in_ready (mask_ready),
        .in_item  (mask_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/bsm_checker.sv @@
`include "background_subtract_mask_unit_macros.svh"

module bsm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bsm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast
);

    logic [bsm_pkg::OUT_DATA_W+1:0] out_word;

    // everything a result transfer carries
    assign out_word = {m_tdata, m_tuser, m_tlast};

    // background pixels come out black
    `BSM_ASSERT_IMPL(a_bg_black, clk, rst_n, m_tvalid && !m_tuser, m_tdata[23:0] == '0)

    // channel sums show only on the last pixel of a frame
    `BSM_ASSERT_IMPL(a_totals_on_last, clk, rst_n, m_tvalid && !m_tlast, m_tdata[104:24] == '0)

    // a stalled result holds
    `BSM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_word))

endmodule

bind background_subtract_mask_unit bsm_checker u_bsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/background_subtract_mask_unit_tb.sv @@
`timescale 1ns / 100ps

module background_subtract_mask_unit_tb;

    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE_CYC  = 8;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_TYPED, ROW_THRESH} row_kind_t;

    typedef struct packed {
        bsm_pkg::pixel_t px;
        logic            fg;
        logic            done;
        bsm_pkg::total_t red_sum;
        bsm_pkg::total_t green_sum;
        bsm_pkg::total_t blue_sum;
    } mask_result_t;

    typedef struct packed {
        row_kind_t                     kind;
        bsm_pkg::pixel_t               px;
        logic                          cap;
        logic                          last;
        logic [bsm_pkg::THRESH_W-1:0]  level;
        mask_result_t                  want;
    } drill_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [bsm_pkg::IN_DATA_W-1:0]   s_tdata;    // red, green, blue
    logic                            s_tuser;    // capture_frame
    logic                            s_tlast;    // frame_last
    logic                            m_tvalid;
    logic                            m_tready;
    // red_out, green_out, blue_out, red_total, green_total, blue_total, zero pad
    logic [bsm_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tuser;    // is_foreground
    logic                            m_tlast;    // frame_done
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bsm_pkg::THRESH_W-1:0]    cfg_data;

    // predictor state
    bsm_pkg::pixel_t                 bg_frame [int];
    int                              scan_pos = 0;
    bsm_pkg::total_t                 red_sum = '0;
    bsm_pkg::total_t                 green_sum = '0;
    bsm_pkg::total_t                 blue_sum = '0;
    logic [bsm_pkg::THRESH_W-1:0]    fg_level = bsm_pkg::THRESH_RESET;

    mask_result_t            pending_masks [$];
    mask_result_t            predicted;
    mask_result_t            want;
    drill_row_t              drill_rows [$];

    // driver side info for rows whose result is typed in
    logic                    drv_typed;
    mask_result_t            drv_want;

    int                      src_idle_pct;
    int                      sink_stall_pct;
    int                      sink_hold;

    int                      err_count;
    int                      pixels_in;
    int                      results_out;
    int                      frames_out;
    int                      fg_out;
    int                      level_writes;

    background_subtract_mask_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // run limit, several times the slowest correct run including the memory clear
    initial
    begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bsm_pkg::pixel_t make_px(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
        make_px = '{blue: b, green: g, red: r};
    endfunction

    function automatic logic [bsm_pkg::THRESH_W-1:0] chan_gap(input logic [7:0] a,
                                                              input logic [7:0] b);
        return (a >= b) ? bsm_pkg::THRESH_W'(a - b) : bsm_pkg::THRESH_W'(b - a);
    endfunction

    function automatic bsm_pkg::total_t sum_clip(input bsm_pkg::total_t acc,
                                                 input logic [7:0] v);
        logic [bsm_pkg::TOTAL_W:0] s;
        s = acc + v;
        return (s > bsm_pkg::TOTAL_MAX) ? bsm_pkg::TOTAL_MAX : s[bsm_pkg::TOTAL_W-1:0];
    endfunction

    // masked pixel and frame sums for one accepted pixel, advancing the predictor state
    function automatic mask_result_t mask_pixel(input bsm_pkg::pixel_t px, input logic cap,
                                                input logic last);
        mask_result_t                  res;
        bsm_pkg::pixel_t               bg_px;
        logic [bsm_pkg::THRESH_W-1:0]  gap;
        if (cap)
            bg_frame[scan_pos] = px;
        bg_px = bg_frame.exists(scan_pos) ? bg_frame[scan_pos] : bsm_pkg::pixel_t'('0);
        gap = chan_gap(px.red, bg_px.red) + chan_gap(px.green, bg_px.green)
            + chan_gap(px.blue, bg_px.blue);
        res = '0;
        res.fg = (gap >= fg_level);
        res.done = last;
        if (res.fg)
        begin
            res.px = px;
            red_sum = sum_clip(red_sum, px.red);
            green_sum = sum_clip(green_sum, px.green);
            blue_sum = sum_clip(blue_sum, px.blue);
        end
        if (last)
        begin
            res.red_sum = red_sum;
            res.green_sum = green_sum;
            res.blue_sum = blue_sum;
            red_sum = '0;
            green_sum = '0;
            blue_sum = '0;
            scan_pos = 0;
        end
        else
            scan_pos = (scan_pos + 1 == bsm_pkg::FRAME_PIXELS) ? 0 : scan_pos + 1;
        return res;
    endfunction

    // channel value near the stored background, clamped to 8 bits
    function automatic logic [7:0] jitter(input logic [7:0] ch);
        int v;
        v = int'(ch) + int'($urandom_range(24)) - 12;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic void check_field(input string name, input longint unsigned exp_val,
                                        input longint unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endfunction

    // directed table builders
    function automatic void add_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic cap, input logic last);
        drill_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.px = make_px(r, g, b);
        row.cap = cap;
        row.last = last;
        drill_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic cap, input logic last,
                                      input logic fg, input bsm_pkg::total_t rs,
                                      input bsm_pkg::total_t gs, input bsm_pkg::total_t bs);
        drill_row_t row;
        row = '0;
        row.kind = ROW_TYPED;
        row.px = make_px(r, g, b);
        row.cap = cap;
        row.last = last;
        row.want.px = fg ? row.px : bsm_pkg::pixel_t'('0);
        row.want.fg = fg;
        row.want.done = last;
        row.want.red_sum = rs;
        row.want.green_sum = gs;
        row.want.blue_sum = bs;
        drill_rows.push_back(row);
    endfunction

    function automatic void add_level(input logic [bsm_pkg::THRESH_W-1:0] v);
        drill_row_t row;
        row = '0;
        row.kind = ROW_THRESH;
        row.level = v;
        drill_rows.push_back(row);
    endfunction

    // offer one pixel, with random gaps, and return at the edge of its transfer
    task automatic send_pixel(input bsm_pkg::pixel_t px, input logic cap, input logic last,
                              input logic typed, input mask_result_t typed_want);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = px;
        s_tuser = cap;
        s_tlast = last;
        drv_typed = typed;
        drv_want = typed_want;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
    endtask

    // stop offering and wait until every expected result has left
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_masks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_level(input logic [bsm_pkg::THRESH_W-1:0] v);
        settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver: random stalls, or a counted hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_tready = 1'b0;
                sink_hold = sink_hold - 1;
            end
            else
                m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // threshold copy follows each register transfer
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            fg_level = cfg_data;
            level_writes++;
        end
    end

    // predict on each input transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted = mask_pixel(bsm_pkg::pixel_t'(s_tdata), s_tuser, s_tlast);
            pending_masks.push_back(drv_typed ? drv_want : predicted);
            pixels_in++;
        end
    end

    // compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_out++;
            if (m_tlast)
                frames_out++;
            if (m_tuser)
                fg_out++;
            if (pending_masks.size() == 0)
            begin
                $error("result transfer with no pixel pending");
                err_count++;
            end
            else
            begin
                want = pending_masks.pop_front();
                check_field("red_out", want.px.red, m_tdata[bsm_pkg::CH_W-1:0]);
                check_field("green_out", want.px.green,
                            m_tdata[bsm_pkg::CH_W +: bsm_pkg::CH_W]);
                check_field("blue_out", want.px.blue,
                            m_tdata[2*bsm_pkg::CH_W +: bsm_pkg::CH_W]);
                check_field("is_foreground", want.fg, m_tuser);
                check_field("frame_done", want.done, m_tlast);
                check_field("red_total", want.red_sum,
                            m_tdata[bsm_pkg::PIX_W +: bsm_pkg::TOTAL_W]);
                check_field("green_total", want.green_sum,
                            m_tdata[bsm_pkg::PIX_W + bsm_pkg::TOTAL_W +: bsm_pkg::TOTAL_W]);
                check_field("blue_total", want.blue_sum,
                            m_tdata[bsm_pkg::PIX_W + 2*bsm_pkg::TOTAL_W +: bsm_pkg::TOTAL_W]);
            end
        end
    end

    // stimulus
    initial
    begin
        drill_row_t       row;
        bsm_pkg::pixel_t  px;
        bsm_pkg::pixel_t  bg_px;
        int               frame_len;
        int               sent;
        logic             cap;
        logic             cap_k;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        drv_typed = 1'b0;
        drv_want = '0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        sink_hold = 0;
        err_count = 0;
        pixels_in = 0;
        results_out = 0;
        frames_out = 0;
        fg_out = 0;
        level_writes = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset threshold against a cleared background: boundary on both sides
        add_typed(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 0, 0, 0);
        add_typed(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b1, 0, 0, 0);
        add_typed(8'd10, 8'd5, 8'd4, 1'b0, 1'b0, 1'b0, 0, 0, 0);
        add_typed(8'd10, 8'd5, 8'd5, 1'b0, 1'b1, 1'b1, 265, 260, 260);
        // capture frame: difference is zero, never foreground; then a frame compared against it
        add_typed(8'd200, 8'd100, 8'd50, 1'b1, 1'b0, 1'b0, 0, 0, 0);
        add_typed(8'd1, 8'd2, 8'd3, 1'b1, 1'b1, 1'b0, 0, 0, 0);
        add_pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b0);
        add_pixel(8'd21, 8'd2, 8'd3, 1'b0, 1'b1);
        // zero threshold: foreground even while capturing
        add_level(10'd0);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
        add_pixel(8'd128, 8'd64, 8'd32, 1'b1, 1'b1);
        // thresholds above the largest difference
        add_level(10'd766);
        add_typed(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, 0, 0, 0);
        add_typed(8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 0, 0, 0);
        add_level(10'd1023);
        add_typed(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0, 0, 0, 0);
        // largest difference exactly at the threshold
        add_level(10'd765);
        add_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
        add_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        add_pixel(8'hAA, 8'h55, 8'hAA, 1'b0, 1'b1);

        foreach (drill_rows[i])
        begin
            row = drill_rows[i];
            if (row.kind == ROW_THRESH)
                write_level(row.level);
            else
                send_pixel(row.px, row.cap, row.last, row.kind == ROW_TYPED, row.want);
        end

        // short captured frame
        for (int k = 0; k < 8; k++)
            send_pixel(make_px(8'(100 + 10*k), 8'd90, 8'd80), 1'b1, k == 7, 1'b0, '0);

        // random frames under four idling plans
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
                default: begin src_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            write_level((ph == 3) ? 10'($urandom_range(1023)) : 10'($urandom_range(5, 60)));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (sent > PHASE_ITEMS / 2 && sent < PHASE_ITEMS / 2 + 13 && ph != 0)
                    write_level(10'($urandom_range(0, 120)));
                frame_len = ($urandom_range(9) == 0) ? $urandom_range(13, 60)
                                                     : $urandom_range(1, 12);
                cap = ($urandom_range(3) == 0);
                for (int k = 0; k < frame_len; k++)
                begin
                    bg_px = bg_frame.exists(k) ? bg_frame[k] : bsm_pkg::pixel_t'('0);
                    if ($urandom_range(1) == 0)
                        px = make_px(jitter(bg_px.red), jitter(bg_px.green),
                                     jitter(bg_px.blue));
                    else
                        px = bsm_pkg::pixel_t'($urandom());
                    // occasional capture flag that breaks the frame's setting
                    cap_k = ($urandom_range(19) == 0) ? ~cap : cap;
                    if (ph == 0 && sent == 40)
                        sink_hold = 400;
                    send_pixel(px, cap_k, k == frame_len - 1, 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        repeat (SETTLE_CYC) @(posedge clk);
        if (pending_masks.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_masks.size());
            err_count++;
        end

        $display("run covered %0d pixels, %0d results, %0d frames, %0d foreground",
                 pixels_in, results_out, frames_out, fg_out);
        $display("threshold transfers: %0d, incl. zero, exact-max and out-of-range levels",
                 level_writes);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
